### hw/rtl/bad_pkg.sv
// ============================================================================
// bad_pkg: shared types and constants for the bearing and distance core
// Holds the word types, the arctangent table and the fixed-point constants.
// ============================================================================
package bad_pkg;

    typedef struct packed {
        logic [29:0] from_x;
        logic [29:0] from_y;
        logic [29:0] to_x;
        logic [29:0] to_y;
    } in_word_t;

    typedef struct packed {
        logic        [30:0] distance;
        logic signed [15:0] bearing;
    } out_word_t;

    // Classified word passed from the front end to the back end.
    typedef struct packed {
        logic [29:0] ax;
        logic [29:0] ay;
        logic        ex_neg;
        logic        ex_zero;
        logic        ny_neg;
        logic        ny_zero;
    } job_t;

    localparam int                 COORD_W      = 30;
    localparam int                 VEC_W        = 64;
    localparam int                 ANG_W        = 36;
    localparam int                 SQ_W         = 62;
    localparam int                 ROOT_W       = 31;
    localparam int                 ROOT_STEPS   = 31;
    localparam logic signed [35:0] QUARTER_TURN = 36'sh040000000;
    localparam logic [15:0]        DEG_90       = 16'd9000;
    localparam logic [15:0]        DEG_180      = 16'd18000;
    localparam logic [15:0]        HUNDREDTHS_TURN = 16'd36000;

    localparam logic [31:0] ARC_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

### hw/rtl/bad_front.sv
// ============================================================================
// bad_front: input stage
// Forms the differences of the point pair, classifies the quadrant and registers the result.
// ============================================================================
module bad_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bad_pkg::in_word_t in_word,
    output logic              in_ready,
    output logic              job_valid,
    output bad_pkg::job_t     job,
    input  logic              job_ready
);

    logic              valid_reg;
    bad_pkg::job_t     job_reg;
    bad_pkg::job_t     job_next;
    logic signed [30:0] ex;
    logic signed [30:0] ny;

    assign in_ready = !valid_reg || job_ready;

    always_comb
    begin
        ex = $signed({1'b0, in_word.to_x}) - $signed({1'b0, in_word.from_x});
        ny = $signed({1'b0, in_word.from_y}) - $signed({1'b0, in_word.to_y});
        job_next.ex_neg  = ex[30];
        job_next.ny_neg  = ny[30];
        job_next.ex_zero = (ex == '0);
        job_next.ny_zero = (ny == '0);
        job_next.ax      = ex[30] ? 30'(-ex) : ex[29:0];
        job_next.ay      = ny[30] ? 30'(-ny) : ny[29:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;

endmodule

### hw/rtl/bad_queue.sv
// ============================================================================
// bad_queue: two-entry word queue
// Decouples the front end from the back end so that each can stall alone.
// ============================================================================
module bad_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    input  bad_pkg::job_t wr_word,
    output logic          wr_ready,
    output logic          rd_valid,
    output bad_pkg::job_t rd_word,
    input  logic          rd_ready
);

    bad_pkg::job_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_wr;
    logic          do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_word  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !wr_ready)
        else $error("queue accepts a word while full");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd && count_reg == 2'd1) |=> (count_reg == 2'd2))
        else $error("queue count lost a write");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> !rd_valid)
        else $error("queue shows a word while empty");

endmodule

### hw/rtl/bad_back.sv
// ============================================================================
// bad_back: arithmetic pipeline
// CORDIC vectoring and a restoring square root run side by side, one step
// per stage, followed by angle scaling, quadrant folding and an output queue.
// ============================================================================
module bad_back #(
    parameter int ROTATION_STAGES = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  bad_pkg::job_t      job,
    output logic               job_ready,
    output logic               out_valid,
    output bad_pkg::out_word_t out_word,
    input  logic               out_ready
);

    localparam int DEPTH = (ROTATION_STAGES > bad_pkg::ROOT_STEPS) ?
                           ROTATION_STAGES : bad_pkg::ROOT_STEPS;
    localparam int LAT   = DEPTH + 4;
    localparam int CNT_W = $clog2(LAT + 3);

    typedef struct packed {
        logic signed [bad_pkg::VEC_W-1:0] x;
        logic signed [bad_pkg::VEC_W-1:0] y;
        logic signed [bad_pkg::ANG_W-1:0] z;
        logic [bad_pkg::SQ_W-1:0]         rem;
        logic [bad_pkg::ROOT_W-1:0]       root;
        logic                             ex_neg;
        logic                             ny_neg;
        logic                             ex_zero;
        logic                             ny_zero;
    } stage_t;

    // Credit count: words in the pipe plus words in the output queue.
    logic [CNT_W-1:0] credit_reg;
    logic             adv;
    logic             pop;
    logic             vld_reg [DEPTH+1];
    stage_t           st_reg  [DEPTH+1];
    logic [bad_pkg::SQ_W-1:0] sq;

    assign pop       = out_valid && out_ready;
    assign job_ready = (credit_reg < CNT_W'(LAT + 2)) || pop;
    assign adv       = job_valid && job_ready;

    always_comb
    begin
        sq = bad_pkg::SQ_W'({32'd0, job.ax} * {32'd0, job.ax})
           + bad_pkg::SQ_W'({32'd0, job.ay} * {32'd0, job.ay});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            for (int i = 0; i <= DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            credit_reg <= credit_reg + CNT_W'(adv) - CNT_W'(pop);
            vld_reg[0] <= adv;
            for (int i = 1; i <= DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Stage 0: square sum and scaled vector.
    always_ff @(posedge clk)
    begin
        st_reg[0].x       <= $signed({4'd0, job.ay, 30'd0});
        st_reg[0].y       <= $signed({4'd0, job.ax, 30'd0});
        st_reg[0].z       <= '0;
        st_reg[0].rem     <= sq;
        st_reg[0].root    <= '0;
        st_reg[0].ex_neg  <= job.ex_neg;
        st_reg[0].ny_neg  <= job.ny_neg;
        st_reg[0].ex_zero <= job.ex_zero;
        st_reg[0].ny_zero <= job.ny_zero;
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_step
        stage_t                   s;
        logic [bad_pkg::SQ_W+1:0] trial;
        logic [bad_pkg::SQ_W+1:0] rem_w;
        localparam int RB = bad_pkg::ROOT_STEPS - 1 - g;
        always_comb
        begin
            s = st_reg[g];
            if (g < ROTATION_STAGES)
            begin
                if (!st_reg[g].y[bad_pkg::VEC_W-1])
                begin
                    s.x = st_reg[g].x + (st_reg[g].y >>> g);
                    s.y = st_reg[g].y - (st_reg[g].x >>> g);
                    s.z = st_reg[g].z + $signed({4'd0, bad_pkg::ARC_TABLE[g % 32]});
                end
                else
                begin
                    s.x = st_reg[g].x - (st_reg[g].y >>> g);
                    s.y = st_reg[g].y + (st_reg[g].x >>> g);
                    s.z = st_reg[g].z - $signed({4'd0, bad_pkg::ARC_TABLE[g % 32]});
                end
            end
            // Restoring root: one result bit per stage, most significant first.
            trial = '0;
            rem_w = {2'd0, st_reg[g].rem};
            if (RB >= 0)
            begin
                trial = ({33'd0, st_reg[g].root} << (RB + 1))
                      + ((bad_pkg::SQ_W+2)'(1) << (2 * RB));
                if (rem_w >= trial)
                begin
                    s.rem  = bad_pkg::SQ_W'(rem_w - trial);
                    s.root = st_reg[g].root | (bad_pkg::ROOT_W'(1) << RB);
                end
            end
        end
        always_ff @(posedge clk)
        begin
            st_reg[g+1] <= s;
        end
    end

    // Finishing stages: clamp and scale, round and fold.
    logic                 v1_reg, v2_reg, v3_reg;
    logic [31:0]          t1_reg;
    stage_t               s1_reg;
    logic [47:0]          p2_reg;
    stage_t               s2_reg;
    bad_pkg::out_word_t   r3_reg;
    logic [15:0]          h;
    logic signed [15:0]   bear;
    logic [30:0]          dist_round;
    logic signed [bad_pkg::ANG_W-1:0] zc;

    always_comb
    begin
        zc = st_reg[DEPTH].z;
        if (zc < 0)
        begin
            zc = '0;
        end
        else if (zc > bad_pkg::QUARTER_TURN)
        begin
            zc = bad_pkg::QUARTER_TURN;
        end
        h = 16'((p2_reg + 48'h80000000) >> 32);
        if (s2_reg.ny_zero)
        begin
            bear = s2_reg.ex_zero ? 16'sd0 :
                   (s2_reg.ex_neg ? -$signed(bad_pkg::DEG_90) : $signed(bad_pkg::DEG_90));
        end
        else if (s2_reg.ex_zero)
        begin
            bear = s2_reg.ny_neg ? $signed(bad_pkg::DEG_180) : 16'sd0;
        end
        else if (!s2_reg.ny_neg)
        begin
            bear = s2_reg.ex_neg ? -$signed(h) : $signed(h);
        end
        else
        begin
            bear = s2_reg.ex_neg ? $signed(h - bad_pkg::DEG_180)
                                 : $signed(bad_pkg::DEG_180 - h);
        end
        dist_round = s2_reg.root + 31'((s2_reg.rem > {31'd0, s2_reg.root}) ? 1 : 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= vld_reg[DEPTH];
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg <= zc[31:0];
        s1_reg <= st_reg[DEPTH];
        p2_reg <= {16'd0, t1_reg} * {32'd0, bad_pkg::HUNDREDTHS_TURN};
        s2_reg <= s1_reg;
        r3_reg.distance <= dist_round;
        r3_reg.bearing  <= bear;
    end

    // Output queue sized by the credit limit, so it never overflows.
    // The oldest word is moved from the memory into an output register.
    localparam int QD = LAT + 2;
    localparam int QA = $clog2(QD);
    bad_pkg::out_word_t oq_reg [QD];
    logic [QA-1:0]      owp_reg, orp_reg;
    logic [CNT_W-1:0]   ocnt_reg;
    bad_pkg::out_word_t head_reg;
    logic               head_valid_reg;
    logic               load;

    assign load      = (ocnt_reg != '0) && (!head_valid_reg || pop);
    assign out_valid = head_valid_reg;
    assign out_word  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owp_reg        <= '0;
            orp_reg        <= '0;
            ocnt_reg       <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            if (v3_reg)
            begin
                owp_reg <= (owp_reg == QA'(QD - 1)) ? '0 : owp_reg + 1'b1;
            end
            if (load)
            begin
                orp_reg <= (orp_reg == QA'(QD - 1)) ? '0 : orp_reg + 1'b1;
            end
            if (load)
            begin
                head_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                head_valid_reg <= 1'b0;
            end
            ocnt_reg <= ocnt_reg + CNT_W'(v3_reg) - CNT_W'(load);
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg)
        begin
            oq_reg[owp_reg] <= r3_reg;
        end
        if (load)
        begin
            head_reg <= oq_reg[orp_reg];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (ocnt_reg < CNT_W'(QD)))
        else $error("output queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= credit_reg)
        else $error("credit count below queued words");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.bearing <= 16'sd18000 && out_word.bearing >= -16'sd18000))
        else $error("bearing out of range");

endmodule

### hw/rtl/bearing_and_distance_core.sv
// ============================================================================
// bearing_and_distance_core: distance and bearing between two map points
// Pipelined CORDIC vectoring and square root behind a small decoupling queue.
// ============================================================================
// Input words (two points in centimetres) are pushed while full is low; one
// result word (distance in cm, bearing in hundredths of a degree) appears per
// input, in order, while empty is low, and is taken with pop.
// Throughput is one word per cycle as long as results are popped as they arrive.
// The path holds the front register, one queue slot, the stage-zero load,
// one stage per CORDIC rotation or square-root bit, the clamp, scale and
// fold stages, the output queue memory and its output register.
// When pop is held low, results collect in the output queue; the back end
// stops taking words once its credit is spent, the decoupling queue fills,
// and full rises. Nothing in flight is dropped.
// Reset clears all valid bits, pointers and counters; the data registers are not reset.
// ============================================================================
module bearing_and_distance_core #(
    parameter int ROTATION_STAGES = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bad_pkg::in_word_t  in_word,
    output logic               empty,
    input  logic               pop,
    output bad_pkg::out_word_t out_word
);

    logic          in_ready;
    logic          f_valid, f_ready;
    bad_pkg::job_t f_job;
    logic          b_valid, b_ready;
    bad_pkg::job_t b_job;
    logic          o_valid;

    assign full  = !in_ready;
    assign empty = !o_valid;

    bad_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(push), .in_word(in_word),
        .in_ready(in_ready), .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
    );

    bad_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_word(f_job),
        .wr_ready(f_ready), .rd_valid(b_valid), .rd_word(b_job), .rd_ready(b_ready)
    );

    bad_back #(.ROTATION_STAGES(ROTATION_STAGES)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(b_valid), .job(b_job),
        .job_ready(b_ready), .out_valid(o_valid), .out_word(out_word),
        .out_ready(pop)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking testbench for bearing_and_distance_core
// Drives point pairs in random bursts, stalls the result side on its own
// pattern, and compares every result word against a CORDIC and square-root
// predictor kept inside this file.
// ============================================================================
module tb;

    localparam int STAGES = 24;
    localparam int DRAIN_CYCLES = 120;

    logic               clk;
    logic               rst_n;
    logic               push = 1'b0;
    logic               full;
    bad_pkg::in_word_t  in_word = '0;
    logic               empty;
    logic               pop = 1'b0;
    bad_pkg::out_word_t out_word;

    bad_pkg::in_word_t  pending_pairs[$];
    bad_pkg::out_word_t expected_fixes[$];
    int        mismatch_count = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        stall_mode = 0;
    int        stall_left = 0;

    bearing_and_distance_core #(.ROTATION_STAGES(STAGES)) uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
        .empty(empty), .pop(pop), .out_word(out_word)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // First-quadrant angle of (a, b) in hundredths of a degree.
    function automatic logic [15:0] quadrant_angle(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [63:0]        scaled;
        x = a <<< 30;
        y = b <<< 30;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> (i % 32);
            dy = x >>> (i % 32);
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + $signed({32'd0, bad_pkg::ARC_TABLE[i % 32]});
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - $signed({32'd0, bad_pkg::ARC_TABLE[i % 32]});
            end
        end
        if (z < 0)
            z = 0;
        if (z > 64'sh40000000)
            z = 64'sh40000000;
        scaled = (64'(z) * 64'd36000 + 64'h80000000) >> 32;
        return scaled[15:0];
    endfunction

    function automatic bad_pkg::out_word_t predict_fix(bad_pkg::in_word_t pair);
        logic signed [63:0] ex;
        logic signed [63:0] ny;
        logic [63:0]        ax;
        logic [63:0]        ay;
        logic [63:0]        sq;
        logic [63:0]        rem;
        logic [63:0]        root;
        logic [63:0]        bitv;
        logic signed [31:0] h;
        logic signed [31:0] brg;
        bad_pkg::out_word_t fix;
        ex = $signed({34'd0, pair.to_x}) - $signed({34'd0, pair.from_x});
        ny = $signed({34'd0, pair.from_y}) - $signed({34'd0, pair.to_y});
        ax = ex < 0 ? -ex : ex;
        ay = ny < 0 ? -ny : ny;
        sq = ax * ax + ay * ay;
        rem = sq;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        if (sq - root * root > root)
            root = root + 1;
        if (ny == 0)
            brg = ex > 0 ? 9000 : (ex < 0 ? -9000 : 0);
        else if (ex == 0)
            brg = ny > 0 ? 0 : 18000;
        else
        begin
            h = $signed({16'd0, quadrant_angle($signed(ay), $signed(ax))});
            if (ny > 0)
                brg = ex > 0 ? h : -h;
            else
                brg = ex > 0 ? 18000 - h : -(18000 - h);
        end
        fix.distance = root[30:0];
        fix.bearing = brg[15:0];
        return fix;
    endfunction

    function automatic logic [29:0] clip_coord(longint v);
        if (v < 0)
            return 30'd0;
        if (v > 64'h3FFFFFFF)
            return 30'h3FFFFFFF;
        return v[29:0];
    endfunction

    function automatic bad_pkg::in_word_t make_pair(longint fx, longint fy,
                                                    longint tx, longint ty);
        bad_pkg::in_word_t pair;
        pair.from_x = clip_coord(fx);
        pair.from_y = clip_coord(fy);
        pair.to_x = clip_coord(tx);
        pair.to_y = clip_coord(ty);
        return pair;
    endfunction

    function automatic bad_pkg::in_word_t random_pair();
        longint bx;
        longint by;
        longint dx;
        longint dy;
        int     pick;
        int     span;
        bx = $urandom_range(32'h3FFFFFFF, 0);
        by = $urandom_range(32'h3FFFFFFF, 0);
        pick = $urandom_range(9, 0);
        if (pick < 3)
            return make_pair(bx, by, $urandom_range(32'h3FFFFFFF, 0),
                             $urandom_range(32'h3FFFFFFF, 0));
        span = $urandom_range(30, 0);
        dx = longint'($urandom()) % (longint'(1) << span);
        dy = longint'($urandom()) % (longint'(1) << span);
        if ($urandom_range(1, 0))
            dx = -dx;
        if ($urandom_range(1, 0))
            dy = -dy;
        if (pick == 3)
            dx = 0;
        else if (pick == 4)
            dy = 0;
        return make_pair(bx, by, bx + dx, by + dy);
    endfunction

    // Sender side: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n || pending_pairs.size() == 0)
        begin
            push <= 1'b0;
        end
        else if (burst_left > 0)
        begin
            push <= 1'b1;
            in_word <= pending_pairs[0];
            burst_left <= burst_left - 1;
        end
        else if (gap_left > 0)
        begin
            push <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else
        begin
            push <= 1'b1;
            in_word <= pending_pairs[0];
            burst_left <= $urandom_range(40, 0);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end
    end

    // Receiver side: switches between free-running, random and heavy stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(2, 0);
                stall_left <= $urandom_range(80, 5);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                0: pop <= 1'b1;
                1: pop <= $urandom_range(1, 0);
                default: pop <= ($urandom_range(5, 0) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            expected_fixes.push_back(predict_fix(pending_pairs[0]));
            void'(pending_pairs.pop_front());
        end
        if (rst_n && pop && !empty)
        begin
            if (expected_fixes.size() == 0)
            begin
                $error("result word with no expectation: distance %0d bearing %0d",
                       out_word.distance, out_word.bearing);
                mismatch_count++;
            end
            else
            begin
                if (out_word.distance !== expected_fixes[0].distance)
                begin
                    $error("distance: expected %0d, got %0d",
                           expected_fixes[0].distance, out_word.distance);
                    mismatch_count++;
                end
                if (out_word.bearing !== expected_fixes[0].bearing)
                begin
                    $error("bearing: expected %0d, got %0d",
                           expected_fixes[0].bearing, out_word.bearing);
                    mismatch_count++;
                end
                void'(expected_fixes.pop_front());
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pairs: same point, the four axes, the corners and each quadrant.
        pending_pairs.push_back(make_pair(0, 0, 0, 0));
        pending_pairs.push_back(make_pair(30'h3FFFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF));
        pending_pairs.push_back(make_pair(100, 500, 900, 500));
        pending_pairs.push_back(make_pair(900, 500, 100, 500));
        pending_pairs.push_back(make_pair(500, 900, 500, 100));
        pending_pairs.push_back(make_pair(500, 100, 500, 900));
        pending_pairs.push_back(make_pair(0, 0, 30'h3FFFFFFF, 0));
        pending_pairs.push_back(make_pair(0, 30'h3FFFFFFF, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 30'h3FFFFFFF, 30'h3FFFFFFF));
        pending_pairs.push_back(make_pair(30'h3FFFFFFF, 30'h3FFFFFFF, 0, 0));
        pending_pairs.push_back(make_pair(0, 30'h3FFFFFFF, 30'h3FFFFFFF, 0));
        pending_pairs.push_back(make_pair(30'h3FFFFFFF, 0, 0, 30'h3FFFFFFF));
        pending_pairs.push_back(make_pair(1000, 1000, 1003, 996));
        pending_pairs.push_back(make_pair(1000, 1000, 997, 996));
        pending_pairs.push_back(make_pair(1000, 1000, 1003, 1004));
        pending_pairs.push_back(make_pair(1000, 1000, 997, 1004));
        pending_pairs.push_back(make_pair(50, 50, 51, 49));
        pending_pairs.push_back(make_pair(50, 50, 51, 30'h3FFFFFFF));
        pending_pairs.push_back(make_pair(0, 30'h3FFFFFFF, 1, 0));
        pending_pairs.push_back(make_pair(0, 1, 30'h3FFFFFFF, 0));
        pending_pairs.push_back(make_pair(12345, 67890, 22345, 57890));
        pending_pairs.push_back(make_pair(700, 300, 699, 301));

        // Hold off the sender until every directed result is back.
        wait (pending_pairs.size() == 0 && expected_fixes.size() == 0);
        for (int n = 0; n < 1600; n++)
            pending_pairs.push_back(random_pair());
        wait (pending_pairs.size() == 0 && expected_fixes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_fixes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
